### src/waveform_column_color_height_core_defines.svh
// Assertion macros shared by the waveform column core.
`ifndef WAVEFORM_COLUMN_COLOR_HEIGHT_CORE_DEFINES_SVH
`define WAVEFORM_COLUMN_COLOR_HEIGHT_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define WCCH_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");
`define WCCH_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define WCCH_ASSERT_SAME(label, pre, post)
`define WCCH_ASSERT_NEXT(label, pre, post)
`endif
`endif

### src/wcch_pkg.sv
// Types, constants and register codes for the waveform column core.
package wcch_pkg;

    localparam int DEFAULT_CHANNELS = 2;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam int GAIN_W  = 24;   // peak times Q4.12 gain
    localparam int GSUM_W  = 50;   // sum of gained squares
    localparam int SSUM_W  = 18;   // sum of raw squares
    localparam int MIX_W   = 34;   // one mixed colour component
    localparam int NUM_W   = 42;   // normalize dividend
    localparam int ROOT_W  = 25;
    localparam int AMP_W   = 33;   // scaled overall amplitude

    localparam logic [7:0]  NORM_FULL   = 8'd255;
    localparam logic [15:0] HEIGHT_MAX  = 16'hFFFF;

    localparam logic [15:0] RESET_GAIN       = 16'd4096;
    localparam logic [23:0] RESET_LOW_COLOR  = 24'hFF0000;
    localparam logic [23:0] RESET_MID_COLOR  = 24'h00FF00;
    localparam logic [23:0] RESET_HIGH_COLOR = 24'h0000FF;
    localparam logic [15:0] RESET_HEIGHT     = 16'd256;

    typedef enum logic [2:0] {
        REG_LOW_GAIN     = 3'd0,
        REG_MID_GAIN     = 3'd1,
        REG_HIGH_GAIN    = 3'd2,
        REG_LOW_COLOR    = 3'd3,
        REG_MID_COLOR    = 3'd4,
        REG_HIGH_COLOR   = 3'd5,
        REG_HEIGHT_SCALE = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic       channel;
        logic [7:0] band_low;
        logic [7:0] band_mid;
        logic [7:0] band_high;
        logic [7:0] band_all;
        logic       column_end;
    } in_item_t;

    typedef struct packed {
        logic        out_channel;
        logic [15:0] bar_height;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } out_item_t;

    typedef struct packed {
        logic [15:0] low_gain;
        logic [15:0] mid_gain;
        logic [15:0] high_gain;
        logic [23:0] low_color;
        logic [23:0] mid_color;
        logic [23:0] high_color;
        logic [15:0] height_scale;
    } cfg_t;

    typedef struct packed {
        logic       channel;
        logic [7:0] peak_low;
        logic [7:0] peak_mid;
        logic [7:0] peak_high;
        logic [7:0] peak_all;
    } job_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

    typedef struct packed {
        logic idle;
        logic done;
    } back_status_t;

endpackage

### src/waveform_column_color_height_core.sv
// Top level of the waveform column colour and height core.
// A sample without a column end only updates the channel's band peaks. A
// column end hands the channel's peaks to a two-deep queue; the engine
// then works through 3 gain products, 3 squares, a divide for the energy
// ratio, a square root, 9 colour products and three normalize divides; the
// ratio divide and the normalize divides share one divider. When the low,
// mid and high peaks are all zero, the divide and square root are skipped.
// Samples keep flowing while the engine works until the queue holds two
// closed columns. Registers are to be written through the cfg port only
// while the core is idle; the core does not enforce it. cfg is always ready.
`include "waveform_column_color_height_core_defines.svh"
module waveform_column_color_height_core #(
    parameter int CHANNELS = wcch_pkg::DEFAULT_CHANNELS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  wcch_pkg::in_item_t  sample,
    output logic                bar_valid,
    input  logic                bar_ready,
    output wcch_pkg::out_item_t bar,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data
);
    import wcch_pkg::*;

    cfg_t         cfg_reg;
    logic         push, pop;
    job_t         push_job, pop_job;
    q_status_t    q_status;
    back_status_t bk_status;

    assign cfg_ready = 1'b1;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_gain     <= RESET_GAIN;
            cfg_reg.mid_gain     <= RESET_GAIN;
            cfg_reg.high_gain    <= RESET_GAIN;
            cfg_reg.low_color    <= RESET_LOW_COLOR;
            cfg_reg.mid_color    <= RESET_MID_COLOR;
            cfg_reg.high_color   <= RESET_HIGH_COLOR;
            cfg_reg.height_scale <= RESET_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LOW_GAIN:     cfg_reg.low_gain     <= cfg_data[15:0];
                REG_MID_GAIN:     cfg_reg.mid_gain     <= cfg_data[15:0];
                REG_HIGH_GAIN:    cfg_reg.high_gain    <= cfg_data[15:0];
                REG_LOW_COLOR:    cfg_reg.low_color    <= cfg_data;
                REG_MID_COLOR:    cfg_reg.mid_color    <= cfg_data;
                REG_HIGH_COLOR:   cfg_reg.high_color   <= cfg_data;
                REG_HEIGHT_SCALE: cfg_reg.height_scale <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    wcch_front #(.CHANNELS(CHANNELS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_valid),
        .in_ready (sample_ready),
        .in_item  (sample),
        .q_full   (q_status.full),
        .push     (push),
        .push_job (push_job)
    );

    wcch_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    wcch_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (!q_status.empty),
        .job       (pop_job),
        .pop       (pop),
        .out_valid (bar_valid),
        .out_ready (bar_ready),
        .out_item  (bar),
        .status    (bk_status)
    );

    // A closed column always lands in the queue
    `WCCH_ASSERT_NEXT(a_push_lands, push, q_status.count != '0)
    // The engine only pops while idle and with a request waiting
    `WCCH_ASSERT_SAME(a_pop_idle, pop, bk_status.idle && !q_status.empty)
    // A finished column returns the engine to idle and shows a result
    `WCCH_ASSERT_NEXT(a_done_idle, bk_status.done, bk_status.idle && bar_valid)

endmodule

### src/wcch_front.sv
// Front end: accept samples, track per-channel band peaks, queue closed columns.
module wcch_front #(
    parameter int CHANNELS = wcch_pkg::DEFAULT_CHANNELS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wcch_pkg::in_item_t in_item,
    input  logic               q_full,
    output logic               push,
    output wcch_pkg::job_t     push_job
);
    import wcch_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [7:0] peak_low_reg  [CHANNELS];
    logic [7:0] peak_mid_reg  [CHANNELS];
    logic [7:0] peak_high_reg [CHANNELS];
    logic [7:0] peak_all_reg  [CHANNELS];

    logic [CH_W-1:0] ch_idx;
    logic            ch_ok;
    logic            accept;
    logic [7:0]      nl, nm, nh, na;

    assign in_ready = !q_full;
    assign ch_idx   = CH_W'(in_item.channel);
    assign ch_ok    = (32'(in_item.channel) < CHANNELS);
    assign accept   = in_valid && in_ready && ch_ok;

    // Fold the sample into the running maxima
    always_comb
    begin
        nl = peak_low_reg[ch_idx];
        nm = peak_mid_reg[ch_idx];
        nh = peak_high_reg[ch_idx];
        na = peak_all_reg[ch_idx];
        if (in_item.band_low  > nl) nl = in_item.band_low;
        if (in_item.band_mid  > nm) nm = in_item.band_mid;
        if (in_item.band_high > nh) nh = in_item.band_high;
        if (in_item.band_all  > na) na = in_item.band_all;
    end

    assign push     = accept && in_item.column_end;
    assign push_job = '{channel: in_item.channel, peak_low: nl, peak_mid: nm,
                        peak_high: nh, peak_all: na};

    // Update peaks; clear them when the column closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                peak_low_reg[i]  <= '0;
                peak_mid_reg[i]  <= '0;
                peak_high_reg[i] <= '0;
                peak_all_reg[i]  <= '0;
            end
        end
        else if (accept)
        begin
            if (in_item.column_end)
            begin
                peak_low_reg[ch_idx]  <= '0;
                peak_mid_reg[ch_idx]  <= '0;
                peak_high_reg[ch_idx] <= '0;
                peak_all_reg[ch_idx]  <= '0;
            end
            else
            begin
                peak_low_reg[ch_idx]  <= nl;
                peak_mid_reg[ch_idx]  <= nm;
                peak_high_reg[ch_idx] <= nh;
                peak_all_reg[ch_idx]  <= na;
            end
        end
    end

endmodule

### src/wcch_queue.sv
// Short request queue between the front end and the column engine.
module wcch_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wcch_pkg::job_t      push_job,
    input  logic                pop,
    output wcch_pkg::job_t      pop_job,
    output wcch_pkg::q_status_t status
);
    import wcch_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign status.count = cnt_reg;
    assign pop_job      = slot_reg[rd_reg];

    // Store pushed requests
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_job;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

### src/wcch_back.sv
// Column engine: gains, energy ratio square root, colour mix, normalize, height.
module wcch_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wcch_pkg::cfg_t         cfg,
    input  logic                   job_valid,
    input  wcch_pkg::job_t         job,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output wcch_pkg::out_item_t    out_item,
    output wcch_pkg::back_status_t status
);
    import wcch_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_GAIN, ST_SQ, ST_DIV, ST_SQRT, ST_AMUL, ST_HMUL,
        ST_MIX, ST_MAX, ST_NSET, ST_NDIV, ST_DONE
    } state_t;

    state_t              state_reg;
    logic                ch_reg;
    logic [7:0]          p_reg [3];
    logic [7:0]          pa_reg;
    logic [GAIN_W-1:0]   g_reg [3];
    logic [GSUM_W-1:0]   gsum_reg;
    logic [SSUM_W-1:0]   ssum_reg;
    logic [1:0]          k_reg, j_reg;
    logic [5:0]          cnt_reg;
    logic [GSUM_W-1:0]   divn_reg;
    logic [MIX_W-1:0]    rem_reg, den_reg;
    logic [GSUM_W-1:0]   r_reg;
    logic [AMP_W-1:0]    a_reg;
    logic [15:0]         h_reg;
    logic [MIX_W-1:0]    acc_reg;
    logic [MIX_W-1:0]    c_reg [3];
    logic [MIX_W-1:0]    m_reg;
    logic [7:0]          res_reg [3];
    logic                out_valid_reg;
    out_item_t           out_reg;

    logic [15:0]         gain_sel;
    logic [23:0]         color_sel;
    logic [7:0]          color_byte;
    logic [GAIN_W-1:0]   gain_prod;
    logic [47:0]         sq_g;
    logic [15:0]         sq_p;
    logic [GSUM_W-1:0]   gsum_new;
    logic [SSUM_W-1:0]   ssum_new;
    logic [MIX_W:0]      rem_sh;
    logic                div_ge;
    logic [MIX_W-1:0]    rem_new;
    logic [GSUM_W-1:0]   divn_new;
    logic [GSUM_W-1:0]   bit_val;
    logic [GSUM_W:0]     sq_sum;
    logic                sq_ge;
    logic [AMP_W-1:0]    a_prod;
    logic [48:0]         h_prod;
    logic [32:0]         h_sh;
    logic [31:0]         mix_prod;
    logic [MIX_W-1:0]    mix_sum;
    logic [MIX_W-1:0]    max_val;
    logic [NUM_W-1:0]    n_val;
    logic                load_out;

    // Select gain and colour byte for the current band and component
    always_comb
    begin
        case (k_reg)
            2'd0:    begin gain_sel = cfg.low_gain;  color_sel = cfg.low_color;  end
            2'd1:    begin gain_sel = cfg.mid_gain;  color_sel = cfg.mid_color;  end
            default: begin gain_sel = cfg.high_gain; color_sel = cfg.high_color; end
        endcase
        case (j_reg)
            2'd0:    color_byte = color_sel[23:16];
            2'd1:    color_byte = color_sel[15:8];
            default: color_byte = color_sel[7:0];
        endcase
    end

    assign gain_prod = GAIN_W'(p_reg[k_reg]) * GAIN_W'(gain_sel);
    assign sq_g      = 48'(g_reg[k_reg]) * 48'(g_reg[k_reg]);
    assign sq_p      = 16'(p_reg[k_reg]) * 16'(p_reg[k_reg]);
    assign gsum_new  = gsum_reg + GSUM_W'(sq_g);
    assign ssum_new  = ssum_reg + SSUM_W'(sq_p);

    // Shared restoring divider step, one quotient bit a cycle
    assign rem_sh   = {rem_reg, divn_reg[GSUM_W-1]};
    assign div_ge   = (rem_sh >= {1'b0, den_reg});
    assign rem_new  = div_ge ? MIX_W'(rem_sh - {1'b0, den_reg}) : MIX_W'(rem_sh);
    assign divn_new = {divn_reg[GSUM_W-2:0], div_ge};

    // Square root step, two radicand bits a cycle
    assign bit_val = GSUM_W'(1) << {cnt_reg, 1'b0};
    assign sq_sum  = (GSUM_W+1)'(r_reg) + (GSUM_W+1)'(bit_val);
    assign sq_ge   = ({1'b0, divn_reg} >= sq_sum);

    assign a_prod   = AMP_W'(pa_reg) * AMP_W'(r_reg[ROOT_W-1:0]);
    assign h_prod   = 49'(a_reg) * 49'(cfg.height_scale);
    assign h_sh     = h_prod[48:16];
    assign mix_prod = 32'(g_reg[k_reg]) * 32'(color_byte);
    assign mix_sum  = acc_reg + MIX_W'(mix_prod);

    always_comb
    begin
        max_val = c_reg[0];
        if (c_reg[1] > max_val) max_val = c_reg[1];
        if (c_reg[2] > max_val) max_val = c_reg[2];
    end

    assign n_val = NUM_W'(c_reg[j_reg]) * NUM_W'(NORM_FULL) + NUM_W'(m_reg >> 1);

    assign pop         = (state_reg == ST_IDLE) && job_valid;
    assign load_out    = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;
    assign out_item    = out_reg;
    assign status.idle = (state_reg == ST_IDLE);
    assign status.done = load_out;

    // Sequence one column through the shared datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            ch_reg        <= 1'b0;
            pa_reg        <= '0;
            gsum_reg      <= '0;
            ssum_reg      <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            cnt_reg       <= '0;
            divn_reg      <= '0;
            rem_reg       <= '0;
            den_reg       <= '0;
            r_reg         <= '0;
            a_reg         <= '0;
            h_reg         <= '0;
            acc_reg       <= '0;
            m_reg         <= '0;
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i]   <= '0;
                g_reg[i]   <= '0;
                c_reg[i]   <= '0;
                res_reg[i] <= '0;
            end
        end
        else
        begin
            // Raise valid on a new result, drop it once the result is taken
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        ch_reg    <= job.channel;
                        p_reg[0]  <= job.peak_low;
                        p_reg[1]  <= job.peak_mid;
                        p_reg[2]  <= job.peak_high;
                        pa_reg    <= job.peak_all;
                        gsum_reg  <= '0;
                        ssum_reg  <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_GAIN;
                    end
                end
                ST_GAIN:
                begin
                    g_reg[k_reg] <= gain_prod;
                    if (k_reg == 2'd2)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_SQ;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                ST_SQ:
                begin
                    gsum_reg <= gsum_new;
                    ssum_reg <= ssum_new;
                    if (k_reg == 2'd2)
                    begin
                        k_reg <= '0;
                        if (ssum_new == '0)
                        begin
                            a_reg     <= {13'd0, pa_reg, 12'd0};
                            state_reg <= ST_HMUL;
                        end
                        else
                        begin
                            divn_reg  <= gsum_new;
                            den_reg   <= MIX_W'(ssum_new);
                            rem_reg   <= '0;
                            cnt_reg   <= 6'(GSUM_W - 1);
                            state_reg <= ST_DIV;
                        end
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                ST_DIV:
                begin
                    rem_reg  <= rem_new;
                    divn_reg <= divn_new;
                    if (cnt_reg == '0)
                    begin
                        r_reg     <= '0;
                        cnt_reg   <= 6'(ROOT_W - 1);
                        state_reg <= ST_SQRT;
                    end
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                ST_SQRT:
                begin
                    if (sq_ge)
                    begin
                        divn_reg <= divn_reg - GSUM_W'(sq_sum);
                        r_reg    <= (r_reg >> 1) + bit_val;
                    end
                    else
                        r_reg <= r_reg >> 1;
                    if (cnt_reg == '0)
                        state_reg <= ST_AMUL;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                ST_AMUL:
                begin
                    a_reg     <= a_prod;
                    state_reg <= ST_HMUL;
                end
                ST_HMUL:
                begin
                    h_reg     <= (h_sh > 33'(HEIGHT_MAX)) ? HEIGHT_MAX : h_sh[15:0];
                    acc_reg   <= '0;
                    k_reg     <= '0;
                    j_reg     <= '0;
                    state_reg <= ST_MIX;
                end
                ST_MIX:
                begin
                    if (k_reg == 2'd2)
                    begin
                        c_reg[j_reg] <= mix_sum;
                        acc_reg      <= '0;
                        k_reg        <= '0;
                        if (j_reg == 2'd2)
                            state_reg <= ST_MAX;
                        else
                            j_reg <= j_reg + 1'b1;
                    end
                    else
                    begin
                        acc_reg <= mix_sum;
                        k_reg   <= k_reg + 1'b1;
                    end
                end
                ST_MAX:
                begin
                    m_reg <= max_val;
                    j_reg <= '0;
                    if (max_val == '0)
                    begin
                        for (int i = 0; i < 3; i++)
                            res_reg[i] <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                        state_reg <= ST_NSET;
                end
                ST_NSET:
                begin
                    divn_reg  <= {n_val, 8'd0};
                    den_reg   <= m_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= 6'(NUM_W - 1);
                    state_reg <= ST_NDIV;
                end
                ST_NDIV:
                begin
                    rem_reg  <= rem_new;
                    divn_reg <= divn_new;
                    if (cnt_reg == '0)
                    begin
                        res_reg[j_reg] <= divn_new[7:0];
                        if (j_reg == 2'd2)
                            state_reg <= ST_DONE;
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= ST_NSET;
                        end
                    end
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        out_reg   <= '{out_channel: ch_reg, bar_height: h_reg,
                                       red: res_reg[0], green: res_reg[1],
                                       blue: res_reg[2]};
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### sim/testbench.sv
// Self-checking bench for the waveform column colour and height core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wcch_pkg::*;

    // Predicts each closed column's bar and holds the bars still owed.
    class bar_scoreboard;
        logic [15:0] gain_l, gain_m, gain_h, scale;
        logic [23:0] col_l, col_m, col_h;
        logic [7:0] pk_l[2], pk_m[2], pk_h[2], pk_a[2];
        out_item_t owed[$];
        int errors;
        int bars_seen;

        function void clear();
            gain_l = RESET_GAIN; gain_m = RESET_GAIN; gain_h = RESET_GAIN;
            col_l = RESET_LOW_COLOR; col_m = RESET_MID_COLOR;
            col_h = RESET_HIGH_COLOR; scale = RESET_HEIGHT;
            for (int i = 0; i < 2; i++)
            begin
                pk_l[i] = 0; pk_m[i] = 0; pk_h[i] = 0; pk_a[i] = 0;
            end
            errors = 0;
            bars_seen = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [23:0] d);
            case (idx)
                REG_LOW_GAIN:     gain_l = d[15:0];
                REG_MID_GAIN:     gain_m = d[15:0];
                REG_HIGH_GAIN:    gain_h = d[15:0];
                REG_LOW_COLOR:    col_l = d;
                REG_MID_COLOR:    col_m = d;
                REG_HIGH_COLOR:   col_h = d;
                REG_HEIGHT_SCALE: scale = d[15:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] int_root(logic [63:0] v);
            logic [63:0] r, bit_w;
            r = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > v) bit_w >>= 2;
            while (bit_w != 0)
            begin
                if (v >= r + bit_w)
                begin
                    v -= r + bit_w;
                    r = (r >> 1) + bit_w;
                end
                else
                    r >>= 1;
                bit_w >>= 2;
            end
            return r;
        endfunction

        function logic [7:0] scale_comp(logic [63:0] c, logic [63:0] m);
            logic [63:0] v;
            v = (c * 255 + (m >> 1)) / m;
            return (v > 255) ? 8'd255 : v[7:0];
        endfunction

        // Fold an accepted sample into the peaks; close the column if marked.
        function void note_sample(in_item_t s);
            logic [63:0] pl, pm, ph, pa, es, gl, gm, gh, eg, amp, ht;
            logic [63:0] c[3], m;
            out_item_t o;
            int ch;
            ch = s.channel;
            if (s.band_low > pk_l[ch]) pk_l[ch] = s.band_low;
            if (s.band_mid > pk_m[ch]) pk_m[ch] = s.band_mid;
            if (s.band_high > pk_h[ch]) pk_h[ch] = s.band_high;
            if (s.band_all > pk_a[ch]) pk_a[ch] = s.band_all;
            if (!s.column_end) return;
            pl = pk_l[ch]; pm = pk_m[ch]; ph = pk_h[ch]; pa = pk_a[ch];
            es = pl * pl + pm * pm + ph * ph;
            gl = pl * gain_l; gm = pm * gain_m; gh = ph * gain_h;
            eg = gl * gl + gm * gm + gh * gh;
            amp = (es != 0) ? pa * int_root(eg / es) : pa << 12;
            ht = (amp * scale) >> 16;
            if (ht > 64'hFFFF) ht = 64'hFFFF;
            for (int k = 0; k < 3; k++)
                c[k] = gl * ((col_l >> (16 - 8 * k)) & 8'hFF)
                     + gm * ((col_m >> (16 - 8 * k)) & 8'hFF)
                     + gh * ((col_h >> (16 - 8 * k)) & 8'hFF);
            m = c[0];
            if (c[1] > m) m = c[1];
            if (c[2] > m) m = c[2];
            o.out_channel = s.channel;
            o.bar_height = ht[15:0];
            o.red = (m == 0) ? 8'd0 : scale_comp(c[0], m);
            o.green = (m == 0) ? 8'd0 : scale_comp(c[1], m);
            o.blue = (m == 0) ? 8'd0 : scale_comp(c[2], m);
            owed.push_back(o);
            pk_l[ch] = 0; pk_m[ch] = 0; pk_h[ch] = 0; pk_a[ch] = 0;
        endfunction

        // Compare one accepted bar with the oldest prediction.
        function void check_bar(out_item_t got);
            out_item_t w;
            bars_seen++;
            if (owed.size() == 0)
            begin
                $error("unexpected bar %h", got);
                errors++;
                return;
            end
            w = owed.pop_front();
            if (got.out_channel !== w.out_channel)
            begin
                $error("out_channel exp %0d got %0d", w.out_channel, got.out_channel);
                errors++;
            end
            if (got.bar_height !== w.bar_height)
            begin
                $error("bar_height exp %0d got %0d", w.bar_height, got.bar_height);
                errors++;
            end
            if (got.red !== w.red)
            begin
                $error("red exp %0d got %0d", w.red, got.red);
                errors++;
            end
            if (got.green !== w.green)
            begin
                $error("green exp %0d got %0d", w.green, got.green);
                errors++;
            end
            if (got.blue !== w.blue)
            begin
                $error("blue exp %0d got %0d", w.blue, got.blue);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic sample_valid, sample_ready;
    in_item_t sample;
    logic bar_valid, bar_ready;
    out_item_t bar;
    logic cfg_valid, cfg_ready;
    logic [2:0] cfg_index;
    logic [23:0] cfg_data;
    bar_scoreboard sb;
    int cycles;
    int samples_sent;
    bit stall_long;

    waveform_column_color_height_core dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
        .bar_valid(bar_valid), .bar_ready(bar_ready), .bar(bar),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        sample_valid = 0; sample = '0; bar_ready = 0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        rst_n = 0;
        sb = new();
        sb.clear();
    end

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                              : $urandom_range(0, 3);
    endfunction

    // Count cycles and drop the run on a hang.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 1500000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Accept bars with random stalls.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (bar_valid && bar_ready) sb.check_bar(bar);
            bar_ready <= stall_long ? ($urandom_range(0, 30) == 0)
                                    : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
        if ($urandom_range(0, 400) == 0) stall_long <= ~stall_long;

    // Valid stays high into the next request when there is no gap.
    task automatic send_sample(in_item_t s);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            sample_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (!sample_ready) @(posedge clk);
        sb.note_sample(s);
        samples_sent++;
    endtask

    task automatic write_cfg(reg_idx_t idx, logic [23:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, d);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold until every owed bar has come and the engine has wound down.
    task automatic drain();
        sample_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic in_item_t rand_sample(int end_odds);
        in_item_t s;
        s.channel = 1'($urandom_range(0, 1));
        s.band_low = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        s.band_mid = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        s.band_high = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        s.band_all = 8'($urandom_range(0, 255));
        s.column_end = ($urandom_range(0, end_odds - 1) == 0);
        return s;
    endfunction

    function automatic in_item_t mk(logic c, logic [7:0] l, logic [7:0] m,
                                    logic [7:0] h, logic [7:0] a, logic e);
        in_item_t s;
        s.channel = c; s.band_low = l; s.band_mid = m;
        s.band_high = h; s.band_all = a; s.column_end = e;
        return s;
    endfunction

    task automatic rand_config();
        for (int r = REG_LOW_GAIN; r <= REG_HEIGHT_SCALE; r++)
        begin
            logic [23:0] d;
            case ($urandom_range(0, 3))
                0: d = 24'h0;
                1: d = 24'hFFFFFF;
                default: d = 24'($urandom);
            endcase
            if (r <= REG_HIGH_GAIN || r == REG_HEIGHT_SCALE)
                d = {8'h0, d[15:0]};
            write_cfg(reg_idx_t'(r), d);
        end
    endtask

    initial
    begin
        cycles = 0;
        samples_sent = 0;
        stall_long = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, extremes, all-zero bands, back-to-back ends.
        send_sample(mk(0, 0, 0, 0, 0, 1));
        send_sample(mk(1, 0, 0, 0, 255, 1));
        send_sample(mk(0, 255, 255, 255, 255, 1));
        send_sample(mk(1, 255, 0, 0, 128, 0));
        send_sample(mk(1, 0, 255, 0, 64, 0));
        send_sample(mk(0, 1, 2, 3, 4, 0));
        send_sample(mk(1, 0, 0, 255, 200, 1));
        send_sample(mk(0, 10, 20, 30, 40, 1));
        send_sample(mk(0, 85, 170, 85, 170, 1));
        drain();
        write_cfg(REG_LOW_GAIN, 24'h00FFFF);
        write_cfg(REG_MID_GAIN, 24'h000000);
        write_cfg(REG_HIGH_GAIN, 24'h00FFFF);
        write_cfg(REG_LOW_COLOR, 24'hFFFFFF);
        write_cfg(REG_MID_COLOR, 24'h000000);
        write_cfg(REG_HIGH_COLOR, 24'h123456);
        write_cfg(REG_HEIGHT_SCALE, 24'h00FFFF);
        send_sample(mk(0, 255, 255, 255, 255, 1));
        send_sample(mk(1, 0, 255, 0, 255, 1));
        send_sample(mk(0, 1, 0, 1, 255, 1));
        drain();
        write_cfg(REG_LOW_GAIN, 24'h0);
        write_cfg(REG_HIGH_GAIN, 24'h0);
        write_cfg(REG_HEIGHT_SCALE, 24'h0);
        send_sample(mk(1, 255, 255, 255, 255, 1));
        drain();

        // Random phases, each with a fresh register setting.
        for (int p = 0; p < 11; p++)
        begin
            rand_config();
            for (int i = 0; i < 48; i++)
                send_sample(rand_sample((p % 3 == 0) ? 2 : 6));
            drain();
        end

        drain();
        $display("Sent %0d samples, checked %0d bars across 14 register settings.",
                 samples_sent, sb.bars_seen);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

### waveform_column_color_height_core.f
+incdir+src
src/wcch_pkg.sv
src/wcch_front.sv
src/wcch_queue.sv
src/wcch_back.sv
src/waveform_column_color_height_core.sv
sim/testbench.sv
